// ===== rtl/sdrs_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrs_pkg
// Shared types and fixed field widths for the SCAN disk request scheduler.
// ----------------------------------------------------------------------------
package sdrs_pkg;

  // fixed field widths of the stream payloads
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned TOT_W       = 17;
  localparam int unsigned SUM_W       = 18;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 72;

  // average divider: one quotient bit per cycle over the 18-bit total
  localparam int unsigned DIV_STEPS = 18;
  localparam int unsigned STEP_W    = 5;

  // commands from the controller to the datapath
  typedef struct packed {
    logic insert;    // accept one request into the sorted chain
    logic prep;      // capture head compares, total, start the divider
    logic find;      // locate the head boundary, set up emission
    logic div_step;  // one divider iteration
    logic emit;      // load the next result into the output register
  } sdrs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_done;   // divider finishes with this step
    logic out_free;   // output register can take a result this cycle
    logic emit_last;  // next result is the final one of the batch
  } sdrs_status_t;

endpackage

// ===== rtl/sdrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdrs_ctrl
// Batch sequencer: load, prepare, find boundary, divide, emit.
// ----------------------------------------------------------------------------
module sdrs_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tlast,
  output logic                    s_tready,
  input  sdrs_pkg::sdrs_status_t  status,
  output sdrs_pkg::sdrs_cmd_t     cmd
);
  import sdrs_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_PREP = 5'b00010,
    ST_FIND = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } sdrs_state_t;

  sdrs_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.insert = 1'b1;
          if (s_tlast) state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_FIND;
      end
      ST_FIND: begin
        cmd.find   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/sdrs_dp.sv =====
// ----------------------------------------------------------------------------
// sdrs_dp
// Datapath: insertion-sorted request chain, seek total, average divider
// and the result output register.
// ----------------------------------------------------------------------------
module sdrs_dp #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TRACK_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [sdrs_pkg::FIELD_W-1:0]       cfg_wr_data,
  input  logic [sdrs_pkg::FIELD_W-1:0]       in_track,
  input  sdrs_pkg::sdrs_cmd_t                cmd,
  output sdrs_pkg::sdrs_status_t             status,
  input  logic                               out_take,
  output logic                               out_valid,
  output logic [sdrs_pkg::OUT_TDATA_W-1:0]   out_data,
  output logic                               out_last
);
  import sdrs_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned REM_W = CNT_W + 1;

  // configuration and batch state
  logic [FIELD_W-1:0]    start_head;
  logic [TRACK_BITS-1:0] head;
  logic [TRACK_BITS-1:0] new_track;
  logic [CNT_W-1:0]      count;
  logic [TRACK_BITS-1:0] max_track;

  // sorted chain
  logic [TRACK_BITS-1:0] chain      [QUEUE_DEPTH];
  logic [TRACK_BITS-1:0] chain_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] greater;
  logic [QUEUE_DEPTH-1:0] at_or_below;
  logic [CNT_W-1:0]      lower_c;
  logic [CNT_W-1:0]      lower;

  // total and divider
  logic [33:0]           sum_wide;
  logic [SUM_W-1:0]      total;
  logic [SUM_W-1:0]      quot;
  logic [REM_W-1:0]      rem;
  logic [REM_W-1:0]      rem_shift;
  logic [STEP_W-1:0]     step;

  // emission
  logic [IDX_W-1:0]      idx;
  logic                  down;
  logic [TRACK_BITS-1:0] pos;
  logic [CNT_W-1:0]      emit_cnt;
  logic [TRACK_BITS-1:0] cur_track;
  logic [TRACK_BITS-1:0] dist_c;
  logic [31:0]           track_wide;
  logic [31:0]           dist_wide;
  logic [31:0]           head_wide;
  logic [31:0]           in_wide;
  logic                  is_last;

  // field masking to track width
  assign head_wide = 32'(start_head);
  assign in_wide   = 32'(in_track);
  assign head      = head_wide[TRACK_BITS-1:0];
  assign new_track = in_wide[TRACK_BITS-1:0];

  // start head register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_head <= '0;
    end else if (cfg_wr_en) begin
      start_head <= cfg_wr_data;
    end
  end

  // per-cell compare against the incoming request
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      greater[i] = (CNT_W'(i) < count) && (chain[i] > new_track);
    end
  end

  // shift-insert: cells above the insertion point move up by one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
        chain_next[i] = chain[(i > 0) ? i - 1 : 0];
      end else if (greater[i] || CNT_W'(i) == count) begin
        chain_next[i] = new_track;
      end else begin
        chain_next[i] = chain[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && count < CNT_W'(QUEUE_DEPTH)) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        chain[i] <= chain_next[i];
      end
    end
  end

  // request count and running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      max_track <= '0;
    end else if (cmd.emit && status.emit_last) begin
      count     <= '0;
      max_track <= '0;
    end else if (cmd.insert && count < CNT_W'(QUEUE_DEPTH)) begin
      count <= count + 1'b1;
      if (new_track > max_track) max_track <= new_track;
    end
  end

  // seek total: head down to 0, then up to the highest request if it lies above head
  assign sum_wide = 34'(head) + ((max_track > head) ? 34'(max_track) : 34'd0);

  // boundary: the at-or-below flags form a thermometer over the sorted chain
  always_comb begin
    lower_c = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (at_or_below[i]) lower_c = CNT_W'(i + 1);
    end
  end

  // restoring divider, one quotient bit per step
  assign rem_shift = {rem[CNT_W-1:0], quot[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        at_or_below[i] <= (CNT_W'(i) < count) && (chain[i] <= head);
      end
      total <= sum_wide[SUM_W-1:0];
      quot  <= sum_wide[SUM_W-1:0];
      rem   <= '0;
      step  <= '0;
    end else if (cmd.div_step) begin
      if (rem_shift >= REM_W'(count)) begin
        rem  <= rem_shift - REM_W'(count);
        quot <= {quot[SUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        quot <= {quot[SUM_W-2:0], 1'b0};
      end
      step <= step + 1'b1;
    end
  end

  // current result: down pass measures down from pos, up pass measures up from pos
  assign cur_track  = chain[idx];
  assign dist_c     = down ? (pos - cur_track) : (cur_track - pos);
  assign track_wide = 32'(cur_track);
  assign dist_wide  = 32'(dist_c);
  assign is_last    = (emit_cnt + 1'b1) == count;

  // emission walk
  always_ff @(posedge clk) begin
    if (cmd.find) begin
      lower    <= lower_c;
      emit_cnt <= '0;
      if (lower_c == '0) begin
        down <= 1'b0;
        idx  <= '0;
        pos  <= '0;
      end else begin
        down <= 1'b1;
        idx  <= IDX_W'(lower_c - 1'b1);
        pos  <= head;
      end
    end else if (cmd.emit) begin
      emit_cnt <= emit_cnt + 1'b1;
      if (down) begin
        if (idx == '0) begin
          down <= 1'b0;
          idx  <= lower[IDX_W-1:0];
          pos  <= '0;
        end else begin
          idx <= idx - 1'b1;
          pos <= cur_track;
        end
      end else begin
        idx <= idx + 1'b1;
        pos <= cur_track;
      end
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data[15:0]  <= track_wide[15:0];
      out_data[31:16] <= dist_wide[15:0];
      out_data[48:32] <= is_last ? total[TOT_W-1:0] : '0;
      out_data[65:49] <= is_last ? quot[TOT_W-1:0] : '0;
      out_data[71:66] <= '0;
      out_last        <= is_last;
    end
  end

  // status to the controller
  assign status.div_done  = (step == STEP_W'(DIV_STEPS - 1));
  assign status.out_free  = !out_valid || out_take;
  assign status.emit_last = is_last;

`ifndef SYNTHESIS
  // stored count never exceeds the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("request count beyond chain depth");

  // non-final results carry no total or average
  a_nonfinal_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_data[65:32] == '0))
    else $error("non-final result carries total or average");

  // emission reads only stored entries
  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (CNT_W'(idx) < count))
    else $error("emission index outside stored requests");

  // a final result is followed by a fresh, empty batch
  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.emit_last) |=> (count == '0))
    else $error("batch not cleared after final result");
`endif

endmodule

// ===== rtl/scan_disk_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// scan_disk_request_scheduler
// SCAN (elevator) scheduling of a batch of disk track requests.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload (lowest bit first)
//  s_*       in         tdata: request_track[15:0]; tlast: last_request
//  m_*       out        tdata: served_track, move_distance, total_seek,
//                              average_seek, zero pad; tlast: last_result
//  cfg_*     in         cfg_wr_data: start_head
//
//  Requests load one per cycle into a sorted chain of QUEUE_DEPTH cells.
//  After the last request the block prepares, finds the boundary and runs
//  the 18-step divider for the average, then emits one result per cycle.
//  No request is taken from the last request until the final result has
//  entered the output register. A stalled m_tready holds emission.
//  rst is synchronous and active high; it empties the batch and clears
//  start_head.
// ----------------------------------------------------------------------------
module scan_disk_request_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TRACK_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [sdrs_pkg::FIELD_W-1:0]         cfg_wr_data,  // start_head
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sdrs_pkg::IN_TDATA_W-1:0]      s_tdata,      // request_track
  input  logic                                 s_tlast,      // last_request
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // served_track[15:0], move_distance[31:16], total_seek[48:32],
  // average_seek[65:49], zero [71:66]
  output logic [sdrs_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tlast       // last_result
);
  import sdrs_pkg::*;

  sdrs_cmd_t    cmd;
  sdrs_status_t status;

  // batch sequencer
  sdrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // chain, divider and output register
  sdrs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TRACK_BITS  (TRACK_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_track    (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_take    (m_tready),
    .out_valid   (m_tvalid),
    .out_data    (m_tdata),
    .out_last    (m_tlast)
  );

endmodule
